### hdl/accumulator_cpu_execute_unit_defines.svh
// Assertion macros shared by the execute unit.
`ifndef ACCUMULATOR_CPU_EXECUTE_UNIT_DEFINES_SVH
`define ACCUMULATOR_CPU_EXECUTE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ACPU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("execute unit: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ACPU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("execute unit: next-cycle check failed");

`endif

### hdl/acpu_pkg.sv
package acpu_pkg;

	// Default machine word width.
	localparam int WORD_BITS_DEF = 11;

	// Fixed widths of the interface fields.
	localparam int CMD_W  = 4;
	localparam int ADDR_W = 11;
	localparam int CHAR_W = 8;

	// Operation codes; code 15 is undefined and falls to the default arm.
	typedef enum logic [CMD_W-1:0] {
		CMD_MOV_A_IMM = 4'd0,
		CMD_MOV_B_IMM = 4'd1,
		CMD_MOV_C_IMM = 4'd2,
		CMD_MOV_A_IND = 4'd3,
		CMD_MOV_B_IND = 4'd4,
		CMD_MOV_C_IND = 4'd5,
		CMD_STORE_A   = 4'd6,
		CMD_STORE_C   = 4'd7,
		CMD_OUT       = 4'd8,
		CMD_ADD       = 4'd9,
		CMD_ADD_C     = 4'd10,
		CMD_SUB       = 4'd11,
		CMD_JMP       = 4'd12,
		CMD_JMP_IND   = 4'd13,
		CMD_JNC       = 4'd14
	} cmd_t;

	// Condition flags.
	typedef struct packed {
		logic zero;
		logic carry;
		logic minus;
	} flags_t;

	// One result item.
	typedef struct packed {
		logic [ADDR_W-1:0] next_pc;
		logic              halt;
		logic              out_valid;
		logic [CHAR_W-1:0] out_char;
	} result_t;

endpackage

### hdl/acpu_dmem.sv
module acpu_dmem
	import acpu_pkg::*;
#(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  logic [WORD_BITS-1:0] rd_addr,
	output logic [WORD_BITS-1:0] rd_data,
	input  logic                 wr_en,
	input  logic [WORD_BITS-1:0] wr_addr,
	input  logic [WORD_BITS-1:0] wr_data,
	output logic                 busy
);

	localparam int DEPTH = 1 << WORD_BITS;

	logic [WORD_BITS-1:0] mem [DEPTH];
	logic [WORD_BITS-1:0] clr_addr_q;
	logic                 clr_busy_q;

	// Clearing sweep after reset: one word per cycle over the whole memory.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == {WORD_BITS{1'b1}}) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// Write port, shared by the sweep and the store operations.
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_addr_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port; a write at the same edge is not seen.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	assign busy = clr_busy_q;

endmodule

### hdl/acpu_exec.sv
module acpu_exec
	import acpu_pkg::*;
#(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  cmd_t                 cmd,
	input  logic [WORD_BITS-1:0] opnd,
	input  logic [WORD_BITS-1:0] here,
	input  logic [WORD_BITS-1:0] mem_data,
	input  logic [WORD_BITS-1:0] reg_a,
	input  logic [WORD_BITS-1:0] reg_b,
	input  logic [WORD_BITS-1:0] reg_c,
	input  flags_t               flags,
	output logic [WORD_BITS-1:0] reg_a_nxt,
	output logic [WORD_BITS-1:0] reg_b_nxt,
	output logic [WORD_BITS-1:0] reg_c_nxt,
	output flags_t               flags_nxt,
	output logic                 wr_en,
	output logic [WORD_BITS-1:0] wr_data,
	output result_t              res
);

	logic [WORD_BITS:0]   sum_ab;
	logic [WORD_BITS:0]   sum_c;
	logic [WORD_BITS:0]   diff_ab;
	logic [WORD_BITS-1:0] pc_inc;
	logic [WORD_BITS-1:0] pc;

	// Arithmetic one bit wider than a word; the top bit is carry or borrow.
	assign sum_ab  = {1'b0, reg_a} + {1'b0, reg_b};
	assign sum_c   = {1'b0, reg_c} + {1'b0, opnd};
	assign diff_ab = {1'b0, reg_a} - {1'b0, reg_b};
	assign pc_inc  = here + 1'b1;

	// Decode and execute one instruction.
	always_comb begin
		reg_a_nxt     = reg_a;
		reg_b_nxt     = reg_b;
		reg_c_nxt     = reg_c;
		flags_nxt     = flags;
		wr_en         = 1'b0;
		wr_data       = reg_a;
		pc            = pc_inc;
		res.halt      = 1'b0;
		res.out_valid = 1'b0;
		res.out_char  = '0;
		case (cmd)
			CMD_MOV_A_IMM: begin
				reg_a_nxt = opnd;
			end
			CMD_MOV_B_IMM: begin
				reg_b_nxt = opnd;
			end
			CMD_MOV_C_IMM: begin
				reg_c_nxt = opnd;
			end
			CMD_MOV_A_IND: begin
				reg_a_nxt = mem_data;
			end
			CMD_MOV_B_IND: begin
				reg_b_nxt = mem_data;
			end
			CMD_MOV_C_IND: begin
				reg_c_nxt = mem_data;
			end
			CMD_STORE_A: begin
				wr_en   = 1'b1;
				wr_data = reg_a;
			end
			CMD_STORE_C: begin
				wr_en   = 1'b1;
				wr_data = reg_c;
			end
			CMD_OUT: begin
				res.out_valid = 1'b1;
				res.out_char  = reg_a[CHAR_W-1:0];
			end
			CMD_ADD: begin
				reg_a_nxt       = sum_ab[WORD_BITS-1:0];
				flags_nxt.zero  = (sum_ab[WORD_BITS-1:0] == '0);
				flags_nxt.minus = sum_ab[WORD_BITS-1];
				flags_nxt.carry = sum_ab[WORD_BITS];
			end
			CMD_ADD_C: begin
				reg_c_nxt       = sum_c[WORD_BITS-1:0];
				flags_nxt.zero  = (sum_c[WORD_BITS-1:0] == '0);
				flags_nxt.minus = sum_c[WORD_BITS-1];
				flags_nxt.carry = sum_c[WORD_BITS];
			end
			CMD_SUB: begin
				reg_a_nxt       = diff_ab[WORD_BITS-1:0];
				flags_nxt.zero  = (diff_ab[WORD_BITS-1:0] == '0);
				flags_nxt.minus = diff_ab[WORD_BITS-1];
				flags_nxt.carry = diff_ab[WORD_BITS];
			end
			CMD_JMP: begin
				pc       = opnd;
				res.halt = (opnd == here);
			end
			CMD_JMP_IND: begin
				pc = mem_data;
			end
			CMD_JNC: begin
				if (!flags.carry) begin
					pc = opnd;
				end
			end
			default: begin
				res.halt = 1'b1;
			end
		endcase
		res.next_pc = ADDR_W'(pc);
	end

endmodule

### hdl/accumulator_cpu_execute_unit.sv
// Execute unit of a small accumulator machine.
// Input channel s_*: one decoded instruction per transfer. s_tuser carries the
// operation code, s_tdata the operand and the instruction's own address.
// Output channel m_*: one result per instruction, in order: the next pc, a
// halt mark and an output character, with out_valid on m_tuser.
// On the way to m_tvalid, the input stage registers the instruction and reads
// the data memory, then the execute logic runs it against registers A, B, C and
// the flags and the result register is loaded.
// Throughput is one instruction per cycle while m_tready is high and the memory
// is not being cleared; a store followed directly by a load from the same
// address is forwarded, so nothing waits on the memory port. After reset all
// registers and flags are zero and the data memory is cleared one word per cycle
// over all 2^WORD_BITS words (2048 at the default width); s_tready stays low
// during that sweep. When the receiver stalls, the result register holds its
// value and one more instruction is held in the input stage; then s_tready
// drops until m_tready returns.
`include "accumulator_cpu_execute_unit_defines.svh"

module accumulator_cpu_execute_unit
	import acpu_pkg::*;
#(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // operand[10:0], instr_addr[21:11], zero pad
	input  logic [3:0]  s_tuser,  // command[3:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // next_pc[10:0], halt[11], out_char[19:12], pad
	output logic        m_tuser   // out_valid
);

	logic                 in_xfer;
	logic                 advance;
	logic                 mem_busy;
	logic [WORD_BITS-1:0] in_opnd;
	logic [WORD_BITS-1:0] in_here;

	cmd_t                 cmd_s1;
	logic [WORD_BITS-1:0] opnd_s1;
	logic [WORD_BITS-1:0] here_s1;
	logic                 s1_valid_q;
	logic                 fwd_s1;
	logic [WORD_BITS-1:0] fwd_data_s1;
	logic [WORD_BITS-1:0] rd_data;
	logic [WORD_BITS-1:0] mem_data;

	logic [WORD_BITS-1:0] reg_a_q, reg_b_q, reg_c_q;
	flags_t               flags_q;
	logic [WORD_BITS-1:0] reg_a_nxt, reg_b_nxt, reg_c_nxt;
	flags_t               flags_nxt;
	logic                 exec_wr;
	logic                 wr_en;
	logic [WORD_BITS-1:0] wr_data;
	result_t              res;
	result_t              out_q;
	logic                 m_valid_q;

	// Operand and address narrowed or widened to the machine word.
	assign in_opnd = WORD_BITS'(s_tdata[ADDR_W-1:0]);
	assign in_here = WORD_BITS'(s_tdata[2*ADDR_W-1:ADDR_W]);

	// Flow control: the input stage moves on when the result register is free.
	assign advance  = s1_valid_q && (!m_valid_q || m_tready);
	assign s_tready = !mem_busy && (!s1_valid_q || advance);
	assign in_xfer  = s_tvalid && s_tready;
	assign wr_en    = exec_wr && advance;

	// Data memory with its clearing sweep.
	acpu_dmem #(
		.WORD_BITS(WORD_BITS)
	) u_dmem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_xfer),
		.rd_addr (in_opnd),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (opnd_s1),
		.wr_data (wr_data),
		.busy    (mem_busy)
	);

	// Input stage payload, with forwarding of a store made at the same edge.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_s1      <= cmd_t'(s_tuser[CMD_W-1:0]);
			opnd_s1     <= in_opnd;
			here_s1     <= in_here;
			fwd_s1      <= wr_en && (opnd_s1 == in_opnd);
			fwd_data_s1 <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_xfer) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	assign mem_data = fwd_s1 ? fwd_data_s1 : rd_data;

	// Execute logic.
	acpu_exec #(
		.WORD_BITS(WORD_BITS)
	) u_exec (
		.cmd       (cmd_s1),
		.opnd      (opnd_s1),
		.here      (here_s1),
		.mem_data  (mem_data),
		.reg_a     (reg_a_q),
		.reg_b     (reg_b_q),
		.reg_c     (reg_c_q),
		.flags     (flags_q),
		.reg_a_nxt (reg_a_nxt),
		.reg_b_nxt (reg_b_nxt),
		.reg_c_nxt (reg_c_nxt),
		.flags_nxt (flags_nxt),
		.wr_en     (exec_wr),
		.wr_data   (wr_data),
		.res       (res)
	);

	// Architectural registers and flags, updated as each instruction retires.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_a_q <= '0;
			reg_b_q <= '0;
			reg_c_q <= '0;
			flags_q <= '0;
		end else if (advance) begin
			reg_a_q <= reg_a_nxt;
			reg_b_q <= reg_b_nxt;
			reg_c_q <= reg_c_nxt;
			flags_q <= flags_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'b0, out_q.out_char, out_q.halt, out_q.next_pc};
	assign m_tuser  = out_q.out_valid;

	// No instruction is taken while the memory is being cleared.
	`ACPU_ASSERT_SAME(a_no_accept_in_clear, clk, arst_n, mem_busy, !s_tready)
	// A full input stage behind a stalled result blocks the input.
	`ACPU_ASSERT_SAME(a_full_blocks, clk, arst_n,
		s1_valid_q && m_valid_q && !m_tready, !s_tready)
	// An accepted instruction occupies the input stage in the next cycle.
	`ACPU_ASSERT_NEXT(a_accept_fills, clk, arst_n, in_xfer, s1_valid_q)
	// A retiring instruction produces a valid result in the next cycle.
	`ACPU_ASSERT_NEXT(a_retire_shows, clk, arst_n, advance, m_tvalid)
	// An output operation never halts.
	`ACPU_ASSERT_SAME(a_out_no_halt, clk, arst_n, m_tvalid && m_tuser, !m_tdata[11])

endmodule

### tb/accumulator_cpu_execute_unit_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the execute unit, runs its own copy of the machine
// state for every accepted instruction and compares each result transfer with
// the oldest predicted one.
module accumulator_cpu_execute_unit_checker
	import acpu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,  // operand[10:0], instr_addr[21:11], zero pad
	input  logic [3:0]  s_tuser,  // command[3:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,  // next_pc[10:0], halt[11], out_char[19:12], pad
	input  logic        m_tuser,  // out_valid
	output int          mismatch_count,
	output int          pending_count,
	output int          result_count
);

	localparam int WORD_BITS = WORD_BITS_DEF;
	localparam int MAX_REPORTS = 10;

	// Shadow copy of the architectural state.
	logic [WORD_BITS-1:0] acc_a;
	logic [WORD_BITS-1:0] acc_b;
	logic [WORD_BITS-1:0] acc_c;
	flags_t               flags;
	logic [WORD_BITS-1:0] data_words [0:(1<<WORD_BITS)-1];

	// Results still owed by the block, oldest first.
	result_t pending_results [$];
	result_t predicted;
	result_t observed;
	logic    fields_differ;

	// Keeps the low word of a wide arithmetic result and updates the flags.
	function automatic logic [WORD_BITS-1:0] settle_flags(input logic [WORD_BITS:0] wide);
		flags.zero  = (wide[WORD_BITS-1:0] == '0);
		flags.minus = wide[WORD_BITS-1];
		flags.carry = wide[WORD_BITS];
		return wide[WORD_BITS-1:0];
	endfunction

	// Carries out one instruction against the shadow state.
	task automatic execute_instr(input logic [CMD_W-1:0] op, input logic [ADDR_W-1:0] opnd,
			input logic [ADDR_W-1:0] here, output result_t res);
		res = '0;
		res.next_pc = here + 1'b1;
		case (op)
			CMD_MOV_A_IMM: acc_a = opnd;
			CMD_MOV_B_IMM: acc_b = opnd;
			CMD_MOV_C_IMM: acc_c = opnd;
			CMD_MOV_A_IND: acc_a = data_words[opnd];
			CMD_MOV_B_IND: acc_b = data_words[opnd];
			CMD_MOV_C_IND: acc_c = data_words[opnd];
			CMD_STORE_A:   data_words[opnd] = acc_a;
			CMD_STORE_C:   data_words[opnd] = acc_c;
			CMD_OUT: begin
				res.out_valid = 1'b1;
				res.out_char = acc_a[CHAR_W-1:0];
			end
			CMD_ADD:   acc_a = settle_flags({1'b0, acc_a} + {1'b0, acc_b});
			CMD_ADD_C: acc_c = settle_flags({1'b0, acc_c} + {1'b0, opnd});
			// The carry of a subtract is the borrow.
			CMD_SUB:   acc_a = settle_flags({1'b0, acc_a} - {1'b0, acc_b});
			CMD_JMP: begin
				res.next_pc = opnd;
				res.halt = (opnd == here);
			end
			// Indirect and conditional jumps never halt.
			CMD_JMP_IND: res.next_pc = data_words[opnd];
			CMD_JNC: begin
				if (!flags.carry) begin
					res.next_pc = opnd;
				end
			end
			// Undefined operation: halt, no state change.
			default: res.halt = 1'b1;
		endcase
	endtask

	// Prediction on input transfers, comparison on output transfers.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_a = '0;
			acc_b = '0;
			acc_c = '0;
			flags = '0;
			for (int i = 0; i < (1 << WORD_BITS); i++) begin
				data_words[i] = '0;
			end
			pending_results.delete();
			mismatch_count = 0;
			pending_count = 0;
			result_count = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				execute_instr(s_tuser, s_tdata[10:0], s_tdata[21:11], predicted);
				pending_results.push_back(predicted);
			end
			if (m_tvalid && m_tready) begin
				result_count++;
				observed.next_pc = m_tdata[10:0];
				observed.halt = m_tdata[11];
				observed.out_char = m_tdata[19:12];
				observed.out_valid = m_tuser;
				if (pending_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS) begin
						$display("%0t: unexpected result transfer %s",
							$realtime, "with nothing predicted");
						$display("    pc=%0d halt=%0b out=%0b char=%02h",
							observed.next_pc, observed.halt, observed.out_valid,
							observed.out_char);
					end
				end else begin
					predicted = pending_results.pop_front();
					fields_differ = (observed.next_pc != predicted.next_pc)
						|| (observed.halt != predicted.halt)
						|| (observed.out_valid != predicted.out_valid)
						|| (observed.out_char != predicted.out_char);
					if (fields_differ) begin
						mismatch_count++;
						if (mismatch_count <= MAX_REPORTS) begin
							$write("%0t: expected pc=%0d halt=%0b out=%0b char=%02h, ",
								$realtime, predicted.next_pc, predicted.halt,
								predicted.out_valid, predicted.out_char);
							$display("got pc=%0d halt=%0b out=%0b char=%02h",
								observed.next_pc, observed.halt, observed.out_valid,
								observed.out_char);
						end
					end
				end
			end
			pending_count = pending_results.size();
		end
	end

endmodule

### tb/accumulator_cpu_execute_unit_test.sv
`timescale 1ns / 1ps

module accumulator_cpu_execute_unit_test;
	import acpu_pkg::*;

	// The package leaves the top operation code unnamed.
	localparam logic [CMD_W-1:0] CMD_UNDEFINED = 4'd15;
	localparam int RANDOM_INSTRS = 900;
	localparam int IDLE_PERCENT = 38;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic [3:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        m_tuser;

	int mismatch_count;
	int pending_count;
	int result_count;
	int sent_count;
	int undefined_count;
	int self_jump_count;
	bit steady = 1'b0;

	logic [CMD_W-1:0]  op;
	logic [ADDR_W-1:0] opnd;
	logic [ADDR_W-1:0] pc;

	accumulator_cpu_execute_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	accumulator_cpu_execute_unit_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.mismatch_count (mismatch_count),
		.pending_count  (pending_count),
		.result_count   (result_count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Receiver back-pressure, switched off during the steady stretch.
	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
	end

	// Offers one instruction after a random gap and holds it until the transfer.
	task automatic issue_instr(input logic [CMD_W-1:0] c, input logic [ADDR_W-1:0] o,
			input logic [ADDR_W-1:0] a);
		while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= c;
		s_tdata <= {2'b00, a, o};
		do @(posedge clk); while (!s_tready);
		sent_count++;
		if (c == CMD_UNDEFINED) begin
			undefined_count++;
		end
		if (c == CMD_JMP && o == a) begin
			self_jump_count++;
		end
	endtask

	// Holds the sender off until every predicted result has been seen.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending_count != 0);
		@(posedge clk);
	endtask

	// Watchdog well beyond the slowest legal run, memory clearing included.
	initial begin
		#3_600_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extremes, every operation, carry and borrow, store then load of
		// one word, a pc that wraps, self-jumps with and without halt, undefined code.
		issue_instr(CMD_MOV_A_IMM, 11'd2047, 11'd0);
		issue_instr(CMD_MOV_B_IMM, 11'd1, 11'd1);
		issue_instr(CMD_ADD, 11'd0, 11'd2);
		issue_instr(CMD_JNC, 11'd100, 11'd3);
		issue_instr(CMD_SUB, 11'd2047, 11'd4);
		issue_instr(CMD_OUT, 11'd0, 11'd5);
		issue_instr(CMD_STORE_A, 11'd2047, 11'd6);
		issue_instr(CMD_MOV_C_IND, 11'd2047, 11'd7);
		issue_instr(CMD_ADD_C, 11'd1, 11'd8);
		issue_instr(CMD_STORE_C, 11'd0, 11'd9);
		issue_instr(CMD_MOV_A_IND, 11'd0, 11'd10);
		issue_instr(CMD_MOV_B_IND, 11'd2047, 11'd11);
		issue_instr(CMD_ADD_C, 11'd1024, 11'd12);
		issue_instr(CMD_JNC, 11'd2047, 11'd13);
		issue_instr(CMD_JMP, 11'd2046, 11'd2047);
		issue_instr(CMD_JMP, 11'd2046, 11'd2046);
		issue_instr(CMD_JMP_IND, 11'd2047, 11'd2047);
		issue_instr(CMD_UNDEFINED, 11'd2047, 11'd2047);
		issue_instr(CMD_MOV_A_IMM, 11'd1234, 11'd0);
		issue_instr(CMD_MOV_B_IMM, 11'd1024, 11'd1);
		issue_instr(CMD_SUB, 11'd0, 11'd2);
		issue_instr(CMD_OUT, 11'd0, 11'd3);
		issue_instr(CMD_MOV_C_IMM, 11'd0, 11'd4);
		issue_instr(CMD_STORE_C, 11'd1, 11'd5);
		issue_instr(CMD_JMP_IND, 11'd1, 11'd6);
		drain_results();

		// Random program: addresses mostly run on, memory addresses often
		// come from a small pool so that loads see earlier stores.
		pc = ADDR_W'($urandom_range(2047));
		for (int n = 0; n < RANDOM_INSTRS; n++) begin
			steady = (n >= 300 && n < 450);
			op = CMD_W'($urandom_range(15));
			if ($urandom_range(1)) begin
				opnd = ADDR_W'($urandom_range(2047));
			end else begin
				opnd = ADDR_W'($urandom_range(7)) | ($urandom_range(1) ? 11'h7F8 : 11'h000);
			end
			if ($urandom_range(19) == 0) begin
				pc = ADDR_W'($urandom_range(2047));
			end
			if ((op == CMD_JMP || op == CMD_JMP_IND || op == CMD_JNC)
					&& $urandom_range(3) == 0) begin
				opnd = pc;
			end
			issue_instr(op, opnd, pc);
			pc = pc + 1'b1;
			if (n == 600) begin
				drain_results();
			end
		end
		steady = 1'b0;
		drain_results();
		repeat (10) @(posedge clk);

		$display("Covered %0d instructions, %0d undefined and %0d direct self-jumps among them.",
			sent_count, undefined_count, self_jump_count);
		$display("%0d results compared under random idling on both channels.", result_count);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
